// ----- rtl/tsd_pkg.sv -----
// ----------------------------------------------------------------------------
// tsd_pkg - shared definitions for the triangle sweep DAC index block
// Field widths, register map, phase constants and fixed-point reciprocals.
// ----------------------------------------------------------------------------
`default_nettype none

package tsd_pkg;

	// Field widths
	localparam int TIME_W = 32;
	localparam int FREQ_W = 20;
	localparam int MED_W  = 12;
	localparam int AMP_W  = 11;
	localparam int PH_W   = 20;
	localparam int NUM_W  = 18;
	localparam int DAC_W  = 12;
	localparam int SPI_W  = 14;
	localparam int QTR_W  = 2;
	localparam int X_W    = PH_W + FREQ_W;

	// Register port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam int DAC_STEPS_DEF = 4096;

	// Full DAC span in mV (twice the reference)
	localparam longint unsigned SPAN_MV = 3780;

	// Phase constants, one period is one million
	localparam longint unsigned PHASE_FULL = 1000000;
	localparam longint unsigned PHASE_3Q   = 750000;
	localparam longint unsigned PHASE_HALF = 500000;
	localparam longint unsigned PHASE_QTR  = 250000;
	localparam longint unsigned ROUND_HALF = 125000;

	// Reciprocals for constant division: q ~ (x * R) >> RECIP_SH, off by at most one
	localparam int RECIP_SH = 40;
	localparam longint unsigned RECIP_FULL = (64'd1 << RECIP_SH) / PHASE_FULL;
	localparam longint unsigned RECIP_QTR  = (64'd1 << RECIP_SH) / PHASE_QTR;
	localparam longint unsigned RECIP_SPAN = (64'd1 << RECIP_SH) / SPAN_MV;
	localparam int RF_W = $clog2(RECIP_FULL + 1);
	localparam int RQ_W = $clog2(RECIP_QTR + 1);

	// Quotient widths of the two phase reductions
	localparam int TQ_W = 13;
	localparam int XQ_W = 20;

	// Register reset values
	localparam logic              MODE_RST   = 1'b0;
	localparam logic [MED_W-1:0]  MEDIAN_RST = '0;
	localparam logic [AMP_W-1:0]  AMP_RST    = '0;
	localparam logic [FREQ_W-1:0] FREQ_RST   = 20'd1000;

	// DAC frame command bits
	localparam logic [SPI_W-1:0] DAC_CMD = 14'h3000;

	typedef enum logic [1:0] {
		REG_MODE   = 2'd0,
		REG_MEDIAN = 2'd1,
		REG_AMP    = 2'd2,
		REG_FREQ   = 2'd3
	} reg_idx_t;

	typedef enum logic [QTR_W-1:0] {
		QTR_RISE_UP  = 2'd0,
		QTR_FALL_MID = 2'd1,
		QTR_FALL_LOW = 2'd2,
		QTR_RISE_MID = 2'd3
	} quarter_t;

	typedef struct packed {
		logic              sweep_mode;
		logic [FREQ_W-1:0] frequency_mhz;
	} sweep_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/tsd_cfg.sv -----
// ----------------------------------------------------------------------------
// tsd_cfg - register file and millivolt to code conversion
// Holds the four settings and derives the median and amplitude codes,
// trunc(mv * DAC_STEPS / 3780), over two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tsd_cfg #(
	parameter int DAC_STEPS = tsd_pkg::DAC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tsd_pkg::ADDR_W-1:0]          paddr,
	input  logic [tsd_pkg::DATA_W-1:0]          pwdata,
	output logic [tsd_pkg::DATA_W-1:0]          prdata,
	output logic                                pready,
	output tsd_pkg::sweep_cfg_t                 sweep,
	output logic signed [$clog2(DAC_STEPS)+1:0] med_code,
	output logic [$clog2(DAC_STEPS)-1:0]        amp_code
);
	import tsd_pkg::*;

	localparam int AW   = $clog2(DAC_STEPS);
	localparam longint unsigned SPAN_K = 64'(DAC_STEPS) * RECIP_SPAN;
	localparam int KW   = $clog2(SPAN_K + 1);
	localparam int KP_W = KW + MED_W + 2;
	localparam int MX_W = MED_W + AW + 1;
	localparam logic signed [AW+1:0] MID_CODE = (AW+2)'(DAC_STEPS / 2);

	logic              mode_q;
	logic [MED_W-1:0]  median_q;
	logic [AMP_W-1:0]  amp_q;
	logic [FREQ_W-1:0] freq_q;
	logic              wr_en;
	reg_idx_t          reg_idx;

	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready  = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RST;
			median_q <= MEDIAN_RST;
			amp_q    <= AMP_RST;
			freq_q   <= FREQ_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MODE:   mode_q   <= pwdata[0];
				REG_MEDIAN: median_q <= pwdata[MED_W-1:0];
				REG_AMP:    amp_q    <= pwdata[AMP_W-1:0];
				REG_FREQ:   freq_q   <= pwdata[FREQ_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_MODE:   prdata = DATA_W'(mode_q);
			REG_MEDIAN: prdata = DATA_W'(median_q);
			REG_AMP:    prdata = DATA_W'(amp_q);
			REG_FREQ:   prdata = DATA_W'(freq_q);
			default:    prdata = '0;
		endcase
	end

	assign sweep.sweep_mode    = mode_q;
	assign sweep.frequency_mhz = freq_q;

	// Median magnitude and sign (-2048 maps to 2048)
	logic             med_neg;
	logic [MED_W-1:0] med_mag;
	assign med_neg = median_q[MED_W-1];
	assign med_mag = med_neg ? (~median_q + 1'b1) : median_q;

	// Quotient estimates through the reciprocal, DAC_STEPS folded in
	logic [KP_W-1:0] med_prod;
	logic [KP_W-1:0] amp_prod;
	assign med_prod = KP_W'(med_mag) * KP_W'(SPAN_K);
	assign amp_prod = KP_W'(amp_q) * KP_W'(SPAN_K);

	logic [AW-1:0]   med_qe_q;
	logic [AW-1:0]   amp_qe_q;
	logic [MX_W-1:0] med_x_q;
	logic [MX_W-1:0] amp_x_q;
	logic            med_neg_q;

	always_ff @(posedge clk) begin
		med_qe_q  <= med_prod[RECIP_SH +: AW];
		amp_qe_q  <= amp_prod[RECIP_SH +: AW];
		med_x_q   <= MX_W'(med_mag) * MX_W'(DAC_STEPS);
		amp_x_q   <= MX_W'(amp_q) * MX_W'(DAC_STEPS);
		med_neg_q <= med_neg;
	end

	// One correction step finishes each quotient
	logic [MX_W-1:0] med_rem;
	logic [MX_W-1:0] amp_rem;
	logic [AW-1:0]   med_fix;
	logic [AW-1:0]   amp_fix;
	assign med_rem = med_x_q - MX_W'(med_qe_q) * MX_W'(SPAN_MV);
	assign amp_rem = amp_x_q - MX_W'(amp_qe_q) * MX_W'(SPAN_MV);
	assign med_fix = (med_rem >= MX_W'(SPAN_MV)) ? med_qe_q + 1'b1 : med_qe_q;
	assign amp_fix = (amp_rem >= MX_W'(SPAN_MV)) ? amp_qe_q + 1'b1 : amp_qe_q;

	logic signed [AW+1:0] med_code_q;
	logic [AW-1:0]        amp_code_q;

	always_ff @(posedge clk) begin
		med_code_q <= med_neg_q ? MID_CODE - $signed({2'b00, med_fix})
		                        : MID_CODE + $signed({2'b00, med_fix});
		amp_code_q <= amp_fix;
	end

	assign med_code = med_code_q;
	assign amp_code = amp_code_q;

endmodule

`default_nettype wire

// ----- rtl/tsd_phase.sv -----
// ----------------------------------------------------------------------------
// tsd_phase - phase pipeline
// Computes (time_ms * frequency_mhz) mod 1000000 in five stages: time is
// reduced modulo one million first, then the product is reduced again.
// ----------------------------------------------------------------------------
`default_nettype none

module tsd_phase (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  logic [tsd_pkg::TIME_W-1:0]  time_ms,
	input  tsd_pkg::sweep_cfg_t         sweep,
	output logic                        phase_valid,
	output logic [tsd_pkg::PH_W-1:0]    phase
);
	import tsd_pkg::*;

	localparam int P1_W = TIME_W + RF_W;
	localparam int P2_W = X_W + RF_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [TIME_W-1:0] t_s1;
	logic [TQ_W-1:0]   q1_s1;
	logic [PH_W-1:0]   t1_s2;
	logic [X_W-1:0]    x_s3;
	logic [X_W-1:0]    x_s4;
	logic [XQ_W-1:0]   q2_s4;
	logic [PH_W-1:0]   ph_s5;

	// Stage 1 math: estimate of time / 1e6
	logic [P1_W-1:0] prod1;
	assign prod1 = P1_W'(time_ms) * P1_W'(RECIP_FULL);

	// Stage 2 math: remainder with one correction
	logic [TIME_W-1:0] rem1;
	logic [TIME_W-1:0] rem1_fix;
	assign rem1     = t_s1 - TIME_W'(q1_s1) * TIME_W'(PHASE_FULL);
	assign rem1_fix = (rem1 >= TIME_W'(PHASE_FULL)) ? rem1 - TIME_W'(PHASE_FULL) : rem1;

	// Stage 4 math: estimate of product / 1e6
	logic [P2_W-1:0] prod2;
	assign prod2 = P2_W'(x_s3) * P2_W'(RECIP_FULL);

	// Stage 5 math: final remainder
	logic [X_W-1:0] rem2;
	logic [X_W-1:0] rem2_fix;
	assign rem2     = x_s4 - X_W'(q2_s4) * X_W'(PHASE_FULL);
	assign rem2_fix = (rem2 >= X_W'(PHASE_FULL)) ? rem2 - X_W'(PHASE_FULL) : rem2;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1  <= time_ms;
			q1_s1 <= prod1[RECIP_SH +: TQ_W];
			t1_s2 <= PH_W'(rem1_fix);
			x_s3  <= X_W'(t1_s2) * X_W'(sweep.frequency_mhz);
			x_s4  <= x_s3;
			q2_s4 <= prod2[RECIP_SH +: XQ_W];
			ph_s5 <= PH_W'(rem2_fix);
		end
	end

	assign phase_valid = v_s5;
	assign phase       = ph_s5;

`ifndef SYNTHESIS
	a_time_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (t1_s2 < PH_W'(PHASE_FULL)))
		else $error("time remainder out of range");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (ph_s5 < PH_W'(PHASE_FULL)))
		else $error("phase out of range");

	a_zero_freq: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && (sweep.frequency_mhz == '0)) |-> (ph_s5 == '0))
		else $error("nonzero phase at zero frequency");
`endif

endmodule

`default_nettype wire

// ----- rtl/tsd_shape.sv -----
// ----------------------------------------------------------------------------
// tsd_shape - waveform pipeline
// Splits the phase into quarters, scales the amplitude code with rounding
// half away from zero, adds the median code and saturates to the DAC range.
// ----------------------------------------------------------------------------
`default_nettype none

module tsd_shape #(
	parameter int DAC_STEPS = tsd_pkg::DAC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                phase_valid,
	input  logic [tsd_pkg::PH_W-1:0]            phase,
	input  tsd_pkg::sweep_cfg_t                 sweep,
	input  logic signed [$clog2(DAC_STEPS)+1:0] med_code,
	input  logic [$clog2(DAC_STEPS)-1:0]        amp_code,
	output logic                                out_valid,
	output logic [tsd_pkg::DAC_W-1:0]           dac_index,
	output logic [tsd_pkg::SPI_W-1:0]           spi_word,
	output logic [tsd_pkg::QTR_W-1:0]           quarter
);
	import tsd_pkg::*;

	localparam int AW   = $clog2(DAC_STEPS);
	localparam int CW   = AW + 2;
	localparam int YW   = NUM_W + AW + 1;
	localparam int P3_W = YW + RQ_W;
	localparam logic signed [CW-1:0] CODE_MAX = CW'(DAC_STEPS - 1);

	logic v_s6, v_s7, v_s8, v_s9, v_s10;

	quarter_t         qtr_s6, qtr_s7, qtr_s8, qtr_s9, qtr_s10;
	logic             neg_s6, neg_s7, neg_s8, neg_s9;
	logic [NUM_W-1:0] num_s6;
	logic [YW-1:0]    y_s7;
	logic [YW-1:0]    y_s8;
	logic [AW-1:0]    q3_s8;
	logic [AW-1:0]    mag_s9;
	logic [DAC_W-1:0] dac_s10;
	logic [SPI_W-1:0] spi_s10;

	// Stage 6 math: quarter, distance from the median crossing, direction
	logic             hold;
	quarter_t         qtr_d;
	logic [NUM_W-1:0] num_d;
	logic             neg_d;

	assign hold = !sweep.sweep_mode || (sweep.frequency_mhz == '0);

	always_comb begin
		if (hold) begin
			qtr_d = QTR_RISE_UP;
			num_d = '0;
			neg_d = 1'b0;
		end else if (phase <= PH_W'(PHASE_QTR)) begin
			qtr_d = QTR_RISE_UP;
			num_d = NUM_W'(phase);
			neg_d = 1'b0;
		end else if (phase <= PH_W'(PHASE_HALF)) begin
			qtr_d = QTR_FALL_MID;
			num_d = NUM_W'(PH_W'(PHASE_HALF) - phase);
			neg_d = 1'b0;
		end else if (phase <= PH_W'(PHASE_3Q)) begin
			qtr_d = QTR_FALL_LOW;
			num_d = NUM_W'(phase - PH_W'(PHASE_HALF));
			neg_d = 1'b1;
		end else begin
			qtr_d = QTR_RISE_MID;
			num_d = NUM_W'(PH_W'(PHASE_FULL) - phase);
			neg_d = 1'b1;
		end
	end

	// Stage 8 math: estimate of rounded product / 250000
	logic [P3_W-1:0] prod3;
	assign prod3 = P3_W'(y_s7) * P3_W'(RECIP_QTR);

	// Stage 9 math: correction
	logic [YW-1:0] rem3;
	assign rem3 = y_s8 - YW'(q3_s8) * YW'(PHASE_QTR);

	// Stage 10 math: offset from the median, saturation, frame
	logic signed [CW-1:0] code;
	logic [AW-1:0]        sat_code;
	logic [DAC_W-1:0]     dac_d;

	assign code = neg_s9 ? med_code - $signed({2'b00, mag_s9})
	                     : med_code + $signed({2'b00, mag_s9});

	always_comb begin
		if (code < 0)
			sat_code = '0;
		else if (code > CODE_MAX)
			sat_code = CODE_MAX[AW-1:0];
		else
			sat_code = code[AW-1:0];
	end

	assign dac_d = DAC_W'(sat_code);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s6  <= phase_valid;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (adv) begin
			qtr_s6  <= qtr_d;
			num_s6  <= num_d;
			neg_s6  <= neg_d;
			qtr_s7  <= qtr_s6;
			neg_s7  <= neg_s6;
			y_s7    <= YW'(num_s6) * YW'(amp_code) + YW'(ROUND_HALF);
			qtr_s8  <= qtr_s7;
			neg_s8  <= neg_s7;
			y_s8    <= y_s7;
			q3_s8   <= prod3[RECIP_SH +: AW];
			qtr_s9  <= qtr_s8;
			neg_s9  <= neg_s8;
			mag_s9  <= (rem3 >= YW'(PHASE_QTR)) ? q3_s8 + 1'b1 : q3_s8;
			qtr_s10 <= qtr_s9;
			dac_s10 <= dac_d;
			spi_s10 <= DAC_CMD | SPI_W'(dac_d);
		end
	end

	assign out_valid = v_s10;
	assign dac_index = dac_s10;
	assign spi_word  = spi_s10;
	assign quarter   = qtr_s10;

`ifndef SYNTHESIS
	a_neg_quarter: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> (neg_s6 == ((qtr_s6 == QTR_FALL_LOW) || (qtr_s6 == QTR_RISE_MID))))
		else $error("direction does not match quarter");

	a_mag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 |-> (mag_s9 <= amp_code))
		else $error("offset exceeds amplitude code");

	a_hold_quarter: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s10 && !sweep.sweep_mode) |-> (qtr_s10 == QTR_RISE_UP))
		else $error("nonzero quarter in constant mode");
`endif

endmodule

`default_nettype wire

// ----- rtl/triangle_sweep_dac_index_top.sv -----
// ----------------------------------------------------------------------------
// triangle_sweep_dac_index_top - triangle sweep DAC code generator
// Turns an elapsed time in ms into a DAC code, its SPI frame and the quarter.
// ----------------------------------------------------------------------------
// Usage:
//   Settings go in through the APB-style port: sweep mode at 0x0, median mV
//   at 0x4, amplitude mV at 0x8, frequency mHz at 0xC. Write them only while
//   no transaction is in flight; the derived codes settle through the tsd_cfg
//   registers after a write.
//   Input channel: in_valid/in_ready with time_ms. Output channel:
//   out_valid/out_ready with dac_index, spi_word and quarter.
//   Pipeline: ten stages, s1 to s5 in tsd_phase and s6 to s10 in tsd_shape.
//   Throughput: one transaction per cycle while the output does not stall,
//   set by the stage pipeline, which holds one item per stage.
//   Stall: when out_valid is high and out_ready low the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated.
//   Reset: the pipeline empties and the registers return to constant mode,
//   median 0 mV, amplitude 0 mV, frequency 1000 mHz.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_sweep_dac_index_top #(
	parameter int DAC_STEPS = tsd_pkg::DAC_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tsd_pkg::ADDR_W-1:0]  paddr,
	input  logic [tsd_pkg::DATA_W-1:0]  pwdata,
	output logic [tsd_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tsd_pkg::TIME_W-1:0]  time_ms,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tsd_pkg::DAC_W-1:0]   dac_index,
	output logic [tsd_pkg::SPI_W-1:0]   spi_word,
	output logic [tsd_pkg::QTR_W-1:0]   quarter
);
	import tsd_pkg::*;

	localparam int AW = $clog2(DAC_STEPS);

	sweep_cfg_t           sweep;
	logic signed [AW+1:0] med_code;
	logic [AW-1:0]        amp_code;
	logic                 adv;
	logic                 phase_valid;
	logic [PH_W-1:0]      phase;

	// Whole pipeline moves unless a finished result is waiting
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	tsd_cfg #(
		.DAC_STEPS (DAC_STEPS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.sweep    (sweep),
		.med_code (med_code),
		.amp_code (amp_code)
	);

	tsd_phase u_phase (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (in_valid),
		.time_ms     (time_ms),
		.sweep       (sweep),
		.phase_valid (phase_valid),
		.phase       (phase)
	);

	tsd_shape #(
		.DAC_STEPS (DAC_STEPS)
	) u_shape (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.phase_valid (phase_valid),
		.phase       (phase),
		.sweep       (sweep),
		.med_code    (med_code),
		.amp_code    (amp_code),
		.out_valid   (out_valid),
		.dac_index   (dac_index),
		.spi_word    (spi_word),
		.quarter     (quarter)
	);

endmodule

`default_nettype wire

// ----- bench/triangle_sweep_dac_index_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_sweep_dac_index_checker - DAC code checker for the sweep block
// Follows register writes on the APB port and computes the DAC code, SPI frame
// and quarter for every accepted time stamp. Compares each delivered result
// against the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------

module triangle_sweep_dac_index_checker #(
	parameter int DAC_STEPS = tsd_pkg::DAC_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tsd_pkg::ADDR_W-1:0]  paddr,
	input  logic [tsd_pkg::DATA_W-1:0]  pwdata,
	input  logic                        pready,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [tsd_pkg::TIME_W-1:0]  time_ms,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [tsd_pkg::DAC_W-1:0]   dac_index,
	input  logic [tsd_pkg::SPI_W-1:0]   spi_word,
	input  logic [tsd_pkg::QTR_W-1:0]   quarter,
	output int                          fail_count,
	output int                          pending
);

	import tsd_pkg::*;

	typedef struct packed {
		logic [DAC_W-1:0] dac_index;
		logic [SPI_W-1:0] spi_word;
		quarter_t         quarter;
	} dac_frame_t;

	// Shadow copy of the sweep settings
	logic              sweep_on;
	logic [MED_W-1:0]  median_mv;
	logic [AMP_W-1:0]  amplitude_mv;
	logic [FREQ_W-1:0] frequency_mhz;

	dac_frame_t dac_frames_due[$];
	dac_frame_t want;

	// Millivolts to DAC steps, truncated toward zero
	function automatic longint mv_to_dac_steps(input longint mv);
		longint mag;
		longint q;
		mag = (mv < 0) ? -mv : mv;
		q = (mag * DAC_STEPS) / longint'(SPAN_MV);
		return (mv < 0) ? -q : q;
	endfunction

	// DAC frame for one time stamp under the current settings
	function automatic dac_frame_t predict_dac_frame(input logic [TIME_W-1:0] t);
		longint            centre;
		longint            height;
		longint            code;
		longint unsigned   phase;
		longint unsigned   num;
		longint unsigned   step;
		logic              below;
		dac_frame_t        f;
		centre = DAC_STEPS / 2 + mv_to_dac_steps(longint'(signed'(median_mv)));
		code = centre;
		f.quarter = QTR_RISE_UP;
		// constant mode and zero frequency both hold the median
		if (sweep_on && frequency_mhz != '0) begin
			phase = (64'(t) * 64'(frequency_mhz)) % PHASE_FULL;
			height = mv_to_dac_steps(longint'(amplitude_mv));
			if (phase <= PHASE_QTR) begin
				f.quarter = QTR_RISE_UP;
				num = phase;
				below = 1'b0;
			end else if (phase <= PHASE_HALF) begin
				f.quarter = QTR_FALL_MID;
				num = PHASE_HALF - phase;
				below = 1'b0;
			end else if (phase <= PHASE_3Q) begin
				f.quarter = QTR_FALL_LOW;
				num = phase - PHASE_HALF;
				below = 1'b1;
			end else begin
				f.quarter = QTR_RISE_MID;
				num = PHASE_FULL - phase;
				below = 1'b1;
			end
			// offset magnitude, rounded half away from zero
			step = (num * 64'(height) + PHASE_QTR / 2) / PHASE_QTR;
			code = below ? centre - longint'(step) : centre + longint'(step);
		end
		// saturate to the DAC range
		if (code < 0)
			code = 0;
		if (code > DAC_STEPS - 1)
			code = DAC_STEPS - 1;
		f.dac_index = code[DAC_W-1:0];
		f.spi_word = DAC_CMD | SPI_W'(f.dac_index);
		return f;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: MISMATCH %s", $realtime, msg);
		fail_count++;
	endtask

	// Settings, predictions and result checks, all on the rising edge
	always @(posedge clk) begin
		if (!arst_n) begin
			sweep_on = MODE_RST;
			median_mv = MEDIAN_RST;
			amplitude_mv = AMP_RST;
			frequency_mhz = FREQ_RST;
			dac_frames_due.delete();
			fail_count = 0;
		end else begin
			if (in_valid && in_ready)
				dac_frames_due.push_back(predict_dac_frame(time_ms));
			if (out_valid && out_ready) begin
				if (dac_frames_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result dac_index=%0d spi_word=%h quarter=%0d",
						dac_index, spi_word, quarter));
				end else begin
					want = dac_frames_due.pop_front();
					if (dac_index !== want.dac_index)
						report_mismatch($sformatf("dac_index got %0d want %0d",
							dac_index, want.dac_index));
					if (spi_word !== want.spi_word)
						report_mismatch($sformatf("spi_word got %h want %h",
							spi_word, want.spi_word));
					if (quarter !== want.quarter)
						report_mismatch($sformatf("quarter got %0d want %0d",
							quarter, want.quarter));
				end
			end
			// register write transaction
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_MODE:   sweep_on = pwdata[0];
					REG_MEDIAN: median_mv = pwdata[MED_W-1:0];
					REG_AMP:    amplitude_mv = pwdata[AMP_W-1:0];
					REG_FREQ:   frequency_mhz = pwdata[FREQ_W-1:0];
					default: ;
				endcase
			end
		end
		pending = dac_frames_due.size();
	end

endmodule

// ----- bench/triangle_sweep_dac_index_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_sweep_dac_index_top_test - testbench for the triangle sweep block
// Drives time stamps and register writes: a directed pass over quarter edges,
// rounding ties, saturation, zero and over-range frequency, then random time
// stamps under several random settings with random idle bursts on both sides.
// ----------------------------------------------------------------------------

module triangle_sweep_dac_index_top_test;

	import tsd_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int LATENCY     = 10;
	localparam int SETS        = 8;
	localparam int SET_ITEMS   = 50;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [TIME_W-1:0]   time_ms = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [DAC_W-1:0]    dac_index;
	logic [SPI_W-1:0]    spi_word;
	logic [QTR_W-1:0]    quarter;

	int fail_count;
	int pending;
	int ready_hold = 0;
	int quiet_cycles = 0;
	bit calm = 1'b0;

	triangle_sweep_dac_index_top dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_ready, .time_ms, .out_valid, .out_ready, .dac_index,
		.spi_word, .quarter
	);

	triangle_sweep_dac_index_checker dac_code_check (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.in_valid, .in_ready, .time_ms, .out_valid, .out_ready, .dac_index,
		.spi_word, .quarter, .fail_count, .pending
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver back-pressure in random bursts
	always @(negedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold = ready_hold - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			ready_hold = $urandom_range(1, 6) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog on cycles with no transaction on any port
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("triangle_sweep_dac_index_top verification failed");
			$finish;
		end
	end

	// One time stamp, with an occasional idle burst ahead of it
	task automatic send_time(input logic [TIME_W-1:0] t);
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid <= 1'b1;
		time_ms <= t;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// New settings only once every result is out; derived codes then settle
	task automatic load_sweep_settings(input logic mode, input logic [MED_W-1:0] med,
			input logic [AMP_W-1:0] amp, input logic [FREQ_W-1:0] freq);
		wait_results_drained();
		write_reg(REG_MODE, DATA_W'(mode));
		write_reg(REG_MEDIAN, DATA_W'(med));
		write_reg(REG_AMP, DATA_W'(amp));
		write_reg(REG_FREQ, DATA_W'(freq));
		repeat (4) @(negedge clk);
	endtask

	task automatic random_sweep_settings();
		logic              mode;
		logic [MED_W-1:0]  med;
		logic [AMP_W-1:0]  amp;
		logic [FREQ_W-1:0] freq;
		mode = ($urandom_range(0, 7) != 0);
		case ($urandom_range(0, 3))
			0: med = 12'h800;
			1: med = 12'h7FF;
			2: med = MED_W'($urandom);
			default: med = MED_W'($urandom_range(0, 3780) - 1890);
		endcase
		case ($urandom_range(0, 3))
			0: amp = '0;
			1: amp = '1;
			2: amp = AMP_W'($urandom);
			default: amp = AMP_W'($urandom_range(0, 1890));
		endcase
		case ($urandom_range(0, 6))
			0: freq = '0;
			1: freq = FREQ_W'($urandom_range(1, 100));
			2: freq = FREQ_W'($urandom_range(1, 5000));
			3: freq = FREQ_W'(1000000);
			4: freq = '1;
			default: freq = FREQ_W'($urandom);
		endcase
		load_sweep_settings(mode, med, amp, freq);
	endtask

	function automatic logic [TIME_W-1:0] pick_time();
		case ($urandom_range(0, 5))
			0: return TIME_W'($urandom_range(0, 100000));
			1: return '1 - TIME_W'($urandom_range(0, 1000));
			default: return TIME_W'($urandom);
		endcase
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: constant mode at mid-scale
		send_time('0);
		send_time('1);

		// full-scale sweep at 1 Hz: quarter edges and the wrap
		load_sweep_settings(1'b1, 12'd0, 11'd1890, 20'd1000);
		send_time(0);
		send_time(125);
		send_time(250);
		send_time(251);
		send_time(500);
		send_time(501);
		send_time(750);
		send_time(751);
		send_time(999);
		send_time(1000);
		send_time('1);

		// lowest median, widest swing, frequency above one million
		load_sweep_settings(1'b1, 12'h800, 11'h7FF, 20'hFFFFF);
		send_time(32'h5555_5555);
		send_time(32'hAAAA_AAAA);
		send_time(1);

		// highest median: clips at the top
		load_sweep_settings(1'b1, 12'h7FF, 11'h7FF, 20'd1000);
		send_time(250);
		send_time(750);

		// zero frequency holds the median
		load_sweep_settings(1'b1, 12'd1890, 11'd1, 20'd0);
		send_time(1234);
		send_time('1);

		// rounding ties on both sides of the median
		load_sweep_settings(1'b1, MED_W'(-1890), 11'd1, 20'd1000);
		send_time(125);
		send_time(625);

		// constant mode ignores amplitude and frequency
		load_sweep_settings(1'b0, 12'd5, 11'd100, 20'd500);
		send_time(100);

		// random settings, the last set with no idling on either side
		for (int s = 0; s < SETS; s++) begin
			random_sweep_settings();
			if (s == SETS - 1)
				calm = 1'b1;
			repeat (SET_ITEMS) send_time(pick_time());
		end

		wait_results_drained();
		repeat (2 * LATENCY) @(posedge clk);
		if (fail_count == 0)
			$display("triangle_sweep_dac_index_top verification clean");
		else
			$display("triangle_sweep_dac_index_top verification failed");
		$finish;
	end

endmodule
